// File: src/sdram_sac_pkg.sv
// Shared types, constants and command codes of the SDRAM single-access controller.
package sdram_sac_pkg;

   localparam int ROW_WIDTH    = 13;
   localparam int BANK_WIDTH   = 3;
   localparam int BEAT_WIDTH   = 16;
   localparam int SOURCE_WIDTH = 4;

   localparam int COL_WIDTH    = 10;
   localparam int ADDR_WIDTH   = ROW_WIDTH + BANK_WIDTH + COL_WIDTH;
   localparam int BEAT_BYTES   = BEAT_WIDTH / 8;
   localparam int WORD_WIDTH   = 2 * BEAT_WIDTH;
   localparam int MASK_WIDTH   = 2 * BEAT_BYTES;
   localparam int WORD_SHIFT   = $clog2(2 * BEAT_BYTES);

   localparam int REFRESH_WIDTH  = 16;
   localparam int RECOVERY_WIDTH = 8;
   localparam int CSR_WIDTH      = 16;

   localparam logic [REFRESH_WIDTH-1:0]  REFRESH_PERIOD_RESET  = 16'd780;
   localparam logic [RECOVERY_WIDTH-1:0] RECOVERY_LENGTH_RESET = 8'd13;

   // Register indexes of the configuration port.
   localparam logic CSR_REFRESH_PERIOD  = 1'b0;
   localparam logic CSR_RECOVERY_LENGTH = 1'b1;

   // Command codes: csn, rasn, casn, wen.
   localparam logic [3:0] CMD_REFRESH  = 4'd1;
   localparam logic [3:0] CMD_ACTIVATE = 4'd3;
   localparam logic [3:0] CMD_WRITE    = 4'd4;
   localparam logic [3:0] CMD_READ     = 4'd5;
   localparam logic [3:0] CMD_DESELECT = 4'd15;

   localparam int PHASE_WIDTH = 3;
   localparam logic [PHASE_WIDTH-1:0] PH_IDLE     = 3'd0;
   localparam logic [PHASE_WIDTH-1:0] PH_CAS      = 3'd1;
   localparam logic [PHASE_WIDTH-1:0] PH_WAIT     = 3'd2;
   localparam logic [PHASE_WIDTH-1:0] PH_FIRST    = 3'd3;
   localparam logic [PHASE_WIDTH-1:0] PH_SECOND   = 3'd4;
   localparam logic [PHASE_WIDTH-1:0] PH_ACK      = 3'd5;
   localparam logic [PHASE_WIDTH-1:0] PH_RECOVERY = 3'd6;

   // Fields of one tick request except req_is_read; the last member is the lowest.
   typedef struct packed {
      logic [BEAT_WIDTH-1:0]   dq_in;
      logic                    dq_read_valid;
      logic                    resp_ready;
      logic [SOURCE_WIDTH-1:0] req_source;
      logic [MASK_WIDTH-1:0]   req_mask;
      logic [WORD_WIDTH-1:0]   req_data;
      logic [ADDR_WIDTH-1:0]   req_address;
      logic                    req_valid;
   } req_fields_type;

   // Fields of one tick result except resp_is_read; the last member is the lowest.
   typedef struct packed {
      logic [SOURCE_WIDTH-1:0] resp_source;
      logic [WORD_WIDTH-1:0]   resp_data;
      logic                    resp_valid;
      logic                    req_ready;
      logic                    dq_write_valid;
      logic [BEAT_BYTES-1:0]   dq_mask;
      logic [BEAT_WIDTH-1:0]   dq_out;
      logic [ROW_WIDTH-1:0]    dram_address;
      logic [BANK_WIDTH-1:0]   bank;
      logic [3:0]              command_code;
   } rsp_fields_type;

   localparam int REQ_FIELDS_WIDTH = $bits(req_fields_type);
   localparam int RSP_FIELDS_WIDTH = $bits(rsp_fields_type);
   localparam int REQ_TDATA_WIDTH  = ((REQ_FIELDS_WIDTH + 7) / 8) * 8;
   localparam int RSP_TDATA_WIDTH  = ((RSP_FIELDS_WIDTH + 7) / 8) * 8;

   typedef struct packed {
      logic                    valid;
      logic                    is_read;
      logic [ADDR_WIDTH-1:0]   address;
      logic [WORD_WIDTH-1:0]   data;
      logic [MASK_WIDTH-1:0]   mask;
      logic [SOURCE_WIDTH-1:0] source;
   } held_type;

   typedef struct packed {
      logic [PHASE_WIDTH-1:0]    phase;
      held_type                  held;
      logic [REFRESH_WIDTH-1:0]  refresh_count;
      logic                      refresh_armed;
      logic                      refresh_pending;
      logic [RECOVERY_WIDTH-1:0] recovery_count;
      logic [WORD_WIDTH-1:0]     read_shift;
   } state_type;

   typedef struct packed {
      logic [REFRESH_WIDTH-1:0]  refresh_period;
      logic [RECOVERY_WIDTH-1:0] recovery_length;
   } config_type;

endpackage

// File: src/sdram_sac_core.sv
// Top level of the SDRAM single-access controller core.
//
// Usage: every request on the req_ channel is one clock tick of a closed-page
// DDR2 command sequencer. It carries the memory request that is offered, the
// response consumer's ready, and the PHY read beat seen in that tick. For each
// accepted request exactly one result leaves on the rsp_ channel. It carries the
// DRAM command, bank, address, write beat and mask, and the response to the
// requester for that tick.
// The csr_ port writes the refresh period (index 0) and the recovery length
// (index 1); write it only while no tick result is outstanding.
// A request that is accepted is captured in the output register and shows its
// result there from the next cycle. Throughput is one request per cycle while the receiver does not stall,
// set by the single result register; a new request is taken in the same cycle
// that the previous result is taken.
// When the receiver stalls, the result register holds its contents and
// req_tready follows rsp_tready, so no tick is lost or repeated.
// Reset is synchronous and active high. It returns the sequencer to idle, empties
// the holding register, clears the refresh and recovery counters, and loads the
// register reset values of 780 and 13.
module sdram_single_access_controller_core (
   input  logic                                      clock,
   input  logic                                      reset,
   // Tick request channel.
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // From bit 0 up: req_valid, req_address, req_data, req_mask, req_source,
   // resp_ready, dq_read_valid, dq_in, zero fill.
   input  logic [sdram_sac_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,
   // Bit 0: req_is_read.
   input  logic [0:0]                                req_tuser,
   // Tick result channel.
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // From bit 0 up: command_code, bank, dram_address, dq_out, dq_mask,
   // dq_write_valid, req_ready, resp_valid, resp_data, resp_source, zero fill.
   output logic [sdram_sac_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata,
   // Bit 0: resp_is_read.
   output logic [0:0]                                rsp_tuser,
   // Configuration write port.
   input  logic                                      csr_we,
   input  logic                                      csr_index,
   input  logic [sdram_sac_pkg::CSR_WIDTH-1:0]       csr_wdata
);

   sdram_sac_pkg::state_type      state_ff;
   sdram_sac_pkg::state_type      state_in;
   sdram_sac_pkg::config_type     cfg_ff;
   sdram_sac_pkg::req_fields_type tick;
   sdram_sac_pkg::rsp_fields_type result;
   sdram_sac_pkg::rsp_fields_type result_ff;
   logic                          result_is_read;
   logic                          result_is_read_ff;
   logic                          rsp_tvalid_ff;
   logic                          accept;

   // A tick is taken whenever the result register is empty or being drained.
   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign tick       = sdram_sac_pkg::req_fields_type'(
                          req_tdata[sdram_sac_pkg::REQ_FIELDS_WIDTH-1:0]);

   sdram_sac_step u_step (
      .state_ff       (state_ff),
      .tick           (tick),
      .tick_is_read   (req_tuser[0]),
      .cfg            (cfg_ff),
      .state_in       (state_in),
      .result         (result),
      .result_is_read (result_is_read)
   );

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.refresh_period  <= sdram_sac_pkg::REFRESH_PERIOD_RESET;
         cfg_ff.recovery_length <= sdram_sac_pkg::RECOVERY_LENGTH_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            sdram_sac_pkg::CSR_REFRESH_PERIOD: begin
               cfg_ff.refresh_period <= csr_wdata[sdram_sac_pkg::REFRESH_WIDTH-1:0];
            end
            sdram_sac_pkg::CSR_RECOVERY_LENGTH: begin
               cfg_ff.recovery_length <= csr_wdata[sdram_sac_pkg::RECOVERY_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Sequencer state advances once per accepted tick. The read shift register
   // and the held address, data and mask carry no reset: they are only used
   // after being written.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase           <= sdram_sac_pkg::PH_IDLE;
         state_ff.held.valid      <= 1'b0;
         state_ff.held.is_read    <= 1'b0;
         state_ff.held.source     <= '0;
         state_ff.refresh_count   <= '0;
         state_ff.refresh_armed   <= 1'b0;
         state_ff.refresh_pending <= 1'b0;
         state_ff.recovery_count  <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (req_tready) begin
         rsp_tvalid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff         <= result;
         result_is_read_ff <= result_is_read;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = sdram_sac_pkg::RSP_TDATA_WIDTH'(result_ff);
   assign rsp_tuser  = result_is_read_ff;

   // The holding register stays full from activate until the response is taken.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == sdram_sac_pkg::PH_CAS || state_ff.phase == sdram_sac_pkg::PH_WAIT ||
       state_ff.phase == sdram_sac_pkg::PH_FIRST ||
       state_ff.phase == sdram_sac_pkg::PH_SECOND ||
       state_ff.phase == sdram_sac_pkg::PH_ACK) |-> state_ff.held.valid)
      else $error("holding register empty during an access");

   // A consumed response moves the sequencer to recovery.
   assert property (@(posedge clock) disable iff (reset)
      (accept && state_ff.phase == sdram_sac_pkg::PH_ACK && tick.resp_ready)
      |=> state_ff.phase == sdram_sac_pkg::PH_RECOVERY)
      else $error("response consumed without entering recovery");

   // A pending refresh in idle always goes to recovery.
   assert property (@(posedge clock) disable iff (reset)
      (accept && state_ff.phase == sdram_sac_pkg::PH_IDLE && state_ff.refresh_pending)
      |=> state_ff.phase == sdram_sac_pkg::PH_RECOVERY)
      else $error("pending refresh not serviced in idle");

   // A consumed request is only ever reported together with a response.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && result_ff.req_ready) |-> result_ff.resp_valid)
      else $error("request consumed without a response");

endmodule

// File: src/sdram_sac_step.sv
// Next-state and command logic of one controller clock tick.
module sdram_sac_step (
   input  sdram_sac_pkg::state_type      state_ff,
   input  sdram_sac_pkg::req_fields_type tick,
   input  logic                          tick_is_read,
   input  sdram_sac_pkg::config_type     cfg,
   output sdram_sac_pkg::state_type      state_in,
   output sdram_sac_pkg::rsp_fields_type result,
   output logic                          result_is_read
);

   logic                                         serviced;
   logic                                         consumed;
   logic                                         armed_now;
   logic                                         refresh_last;
   logic                                         recovery_last;
   logic                                         is_put;
   logic [sdram_sac_pkg::BANK_WIDTH-1:0]         bank_of;
   logic [sdram_sac_pkg::REFRESH_WIDTH-1:0]      refresh_bound;
   logic [sdram_sac_pkg::RECOVERY_WIDTH-1:0]     recovery_bound;

   assign is_put         = !state_ff.held.is_read;
   assign bank_of        = state_ff.held.address[sdram_sac_pkg::COL_WIDTH +:
                                                 sdram_sac_pkg::BANK_WIDTH];
   assign armed_now      = state_ff.refresh_armed || state_ff.held.valid;
   assign refresh_bound  = cfg.refresh_period - 1'b1;
   assign recovery_bound = cfg.recovery_length - 1'b1;
   assign refresh_last   = state_ff.refresh_count == refresh_bound;
   assign recovery_last  = state_ff.recovery_count == recovery_bound;

   always_comb begin
      result                = '0;
      result.command_code   = sdram_sac_pkg::CMD_DESELECT;
      result.resp_data      = state_ff.read_shift;
      result.resp_source    = state_ff.held.source;
      result_is_read        = state_ff.held.is_read;
      serviced              = 1'b0;
      consumed              = 1'b0;
      state_in              = state_ff;

      unique case (state_ff.phase)
         sdram_sac_pkg::PH_IDLE: begin
            if (state_ff.held.valid) begin
               result.command_code = sdram_sac_pkg::CMD_ACTIVATE;
               result.dram_address = state_ff.held.address[
                  sdram_sac_pkg::COL_WIDTH + sdram_sac_pkg::BANK_WIDTH +:
                  sdram_sac_pkg::ROW_WIDTH];
               result.bank         = bank_of;
               state_in.phase      = sdram_sac_pkg::PH_CAS;
            end
            // Refresh wins; the bank and row set for a held request's activate stay on the bus.
            if (state_ff.refresh_pending) begin
               result.command_code = sdram_sac_pkg::CMD_REFRESH;
               serviced            = 1'b1;
               state_in.phase      = sdram_sac_pkg::PH_RECOVERY;
            end
         end
         sdram_sac_pkg::PH_CAS: begin
            result.command_code = state_ff.held.is_read ? sdram_sac_pkg::CMD_READ
                                                        : sdram_sac_pkg::CMD_WRITE;
            // Column with the word offset cleared and auto-precharge in bit ten.
            result.dram_address = sdram_sac_pkg::ROW_WIDTH'({1'b1,
               state_ff.held.address[sdram_sac_pkg::COL_WIDTH-1:sdram_sac_pkg::WORD_SHIFT],
               {sdram_sac_pkg::WORD_SHIFT{1'b0}}});
            result.bank         = bank_of;
            state_in.phase      = sdram_sac_pkg::PH_WAIT;
         end
         sdram_sac_pkg::PH_WAIT: begin
            state_in.phase = sdram_sac_pkg::PH_FIRST;
         end
         sdram_sac_pkg::PH_FIRST: begin
            result.dq_write_valid = is_put;
            result.dq_out  = state_ff.held.data[sdram_sac_pkg::BEAT_WIDTH-1:0];
            result.dq_mask = ~state_ff.held.mask[sdram_sac_pkg::BEAT_BYTES-1:0];
            if (is_put || tick.dq_read_valid) begin
               state_in.phase = sdram_sac_pkg::PH_SECOND;
            end
         end
         sdram_sac_pkg::PH_SECOND: begin
            result.dq_write_valid = is_put;
            result.dq_out  = state_ff.held.data[sdram_sac_pkg::BEAT_WIDTH +:
                                                sdram_sac_pkg::BEAT_WIDTH];
            result.dq_mask = ~state_ff.held.mask[sdram_sac_pkg::BEAT_BYTES +:
                                                 sdram_sac_pkg::BEAT_BYTES];
            state_in.phase = sdram_sac_pkg::PH_ACK;
         end
         sdram_sac_pkg::PH_ACK: begin
            result.resp_valid = 1'b1;
            if (tick.resp_ready) begin
               consumed       = 1'b1;
               state_in.phase = sdram_sac_pkg::PH_RECOVERY;
            end
         end
         sdram_sac_pkg::PH_RECOVERY: begin
            state_in.recovery_count = recovery_last ? '0 : state_ff.recovery_count + 1'b1;
            if (recovery_last) begin
               state_in.phase = sdram_sac_pkg::PH_IDLE;
            end
         end
         default: begin
            state_in.phase = sdram_sac_pkg::PH_IDLE;
         end
      endcase

      result.req_ready = consumed;

      state_in.refresh_pending = refresh_last || (state_ff.refresh_pending && !serviced);
      if (armed_now) begin
         state_in.refresh_count = refresh_last ? '0 : state_ff.refresh_count + 1'b1;
      end
      state_in.refresh_armed = armed_now;

      if (tick.dq_read_valid) begin
         state_in.read_shift = {tick.dq_in,
            state_ff.read_shift[sdram_sac_pkg::WORD_WIDTH-1:sdram_sac_pkg::BEAT_WIDTH]};
      end

      if (consumed) begin
         state_in.held.valid = 1'b0;
      end
      if ((!state_ff.held.valid || consumed) && tick.req_valid) begin
         state_in.held.valid   = 1'b1;
         state_in.held.is_read = tick_is_read;
         state_in.held.address = tick.req_address;
         state_in.held.data    = tick.req_data;
         state_in.held.mask    = tick.req_mask;
         state_in.held.source  = tick.req_source;
      end
   end

endmodule
